// ===== hw/rtl/los_pkg.sv =====
// los_pkg: shared types and constants for the line-of-sight occlusion test
// holds the queued item record, the register index codes and the datapath widths
// no dependencies
package los_pkg;

	localparam int COORD_W    = 16;
	localparam int SIZE_W     = 15;
	localparam int RAD_W      = 15;
	localparam int SKIP_W     = 9;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 15;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = 2;

	localparam int PROD_W = 36;
	localparam int NUM_W  = 37;
	localparam int NUM_EDGES = 4;

	// 64 px in Q12.4
	localparam logic signed [17:0] SIGHT_Y_OFS = 18'sd1024;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_VIEW_RADIUS = 1'b0,
		REG_SKIP_INDEX  = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] viewer_x;
		logic signed [COORD_W-1:0] viewer_y;
		logic signed [COORD_W-1:0] self_x;
		logic signed [COORD_W-1:0] self_y;
		logic signed [COORD_W-1:0] rect_x;
		logic signed [COORD_W-1:0] rect_y;
		logic [SIZE_W-1:0]         rect_w;
		logic [SIZE_W-1:0]         rect_h;
		logic                      test;
		logic                      last;
	} los_item_t;

endpackage

// ===== hw/rtl/los_front.sv =====
// los_front: input side, accepts transactions and classifies each rectangle
// tracks the rectangle position per query and applies the skip and list limits
// depends on los_pkg
module los_front import los_pkg::*; #(
	parameter int MAX_RECTS = 256
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	output logic                      full,
	input  logic signed [COORD_W-1:0] viewer_x,
	input  logic signed [COORD_W-1:0] viewer_y,
	input  logic signed [COORD_W-1:0] self_x,
	input  logic signed [COORD_W-1:0] self_y,
	input  logic signed [COORD_W-1:0] rect_x,
	input  logic signed [COORD_W-1:0] rect_y,
	input  logic [SIZE_W-1:0]         rect_w,
	input  logic [SIZE_W-1:0]         rect_h,
	input  logic                      has_rect,
	input  logic                      last,
	input  logic [SKIP_W-1:0]         skip_index,
	input  logic                      fifo_full,
	output logic                      wr_en,
	output los_item_t                 wr_item
);

	localparam int POS_W = $clog2(MAX_RECTS + 1);

	logic [POS_W-1:0] pos_q;
	logic             accept;
	logic             in_range;
	logic             skip_hit;
	logic             take;
	logic             test;

	assign full     = fifo_full;
	assign accept   = push && !fifo_full;
	assign in_range = pos_q < POS_W'(MAX_RECTS);
	assign skip_hit = !skip_index[SKIP_W-1] &&
		(32'(pos_q) == 32'(skip_index[SKIP_W-2:0]));
	assign take     = has_rect && in_range;
	assign test     = take && !skip_hit;

	// items that neither test nor end a query are dropped here
	assign wr_en = accept && (test || last);

	always_comb begin
		wr_item.viewer_x = viewer_x;
		wr_item.viewer_y = viewer_y;
		wr_item.self_x   = self_x;
		wr_item.self_y   = self_y;
		wr_item.rect_x   = rect_x;
		wr_item.rect_y   = rect_y;
		wr_item.rect_w   = rect_w;
		wr_item.rect_h   = rect_h;
		wr_item.test     = test;
		wr_item.last     = last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (accept) begin
			if (last) begin
				pos_q <= '0;
			end else if (take) begin
				pos_q <= pos_q + 1'b1;
			end
		end
	end

endmodule

// ===== hw/rtl/los_fifo.sv =====
// los_fifo: short item queue between the front and back parts
// flop storage, one write and one read port
// depends on los_pkg
module los_fifo import los_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      wr_en,
	input  los_item_t wr_item,
	output logic      full,
	input  logic      rd_en,
	output los_item_t rd_item,
	output logic      empty
);

	los_item_t          mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q;
	logic [FIFO_AW-1:0] rd_ptr_q;
	logic [FIFO_AW:0]   count_q;
	logic               do_wr;
	logic               do_rd;

	assign full    = count_q == (FIFO_AW+1)'(FIFO_DEPTH);
	assign empty   = count_q == '0;
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== hw/rtl/los_back.sv =====
// los_back: back part, segment against rectangle edge tests and verdict
// three pipeline stages (differences, products, numerators) and a result register
// depends on los_pkg
module los_back import los_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [RAD_W-1:0]  view_radius,
	input  logic              item_valid,
	input  los_item_t         item,
	output logic              item_pop,
	input  logic              pop,
	output logic              empty,
	output logic              visible
);

	function automatic logic edge_hit(
		input logic signed [NUM_W-1:0] den,
		input logic signed [NUM_W-1:0] na,
		input logic signed [NUM_W-1:0] nb
	);
		logic res;
		if (den == '0) begin
			res = 1'b0;
		end else if (den > 0) begin
			res = (na >= 0) && (na <= den) && (nb >= 0) && (nb <= den);
		end else begin
			res = (na <= 0) && (na >= den) && (nb <= 0) && (nb >= den);
		end
		return res;
	endfunction

	logic adv;

	// stage 1: differences
	logic                     v_s1, test_s1, last_s1;
	logic signed [16:0]       ex_s1, dyr_s1, ux0_s1, uy0_s1;
	logic signed [17:0]       ey_s1, ux1_s1, uy1_s1;
	logic signed [SIZE_W:0]   rw_s1, rh_s1;

	// stage 2: products
	logic                     v_s2, test_s2, last_s2;
	logic signed [PROD_W-1:0] pv_den_s2, pv_na0_s2, pv_na1_s2;
	logic signed [PROD_W-1:0] ph_den_s2, ph_na0_s2, ph_na1_s2;
	logic signed [PROD_W-1:0] pe_y0_s2, pe_y1_s2, pe_x0_s2, pe_x1_s2;
	logic signed [33:0]       dx2_s2, dy2_s2;
	logic [2*RAD_W-1:0]       rsq_s2;

	// stage 3: per edge terms
	logic                     v_s3, test_s3, last_s3, inside_s3;
	logic signed [NUM_W-1:0]  den_s3 [NUM_EDGES];
	logic signed [NUM_W-1:0]  na_s3  [NUM_EDGES];
	logic signed [NUM_W-1:0]  nb_s3  [NUM_EDGES];

	logic                     blocked_q;
	logic                     out_v_q;
	logic                     visible_q;

	logic signed [34:0]       dsq_d;
	logic                     inside_d;
	logic [NUM_EDGES-1:0]     edge_d;
	logic                     hit_d;

	assign adv      = !out_v_q || pop;
	assign item_pop = adv && item_valid;
	assign empty    = !out_v_q;
	assign visible  = visible_q;

	assign dsq_d    = 35'(dx2_s2) + 35'(dy2_s2);
	assign inside_d = dsq_d < $signed({5'b0, rsq_s2});

	always_comb begin
		for (int i = 0; i < NUM_EDGES; i++) begin
			edge_d[i] = edge_hit(den_s3[i], na_s3[i], nb_s3[i]);
		end
		hit_d = test_s3 && inside_s3 && (|edge_d);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			test_s1 <= item.test;
			last_s1 <= item.last;
			ex_s1   <= 17'(item.self_x) - 17'(item.viewer_x);
			dyr_s1  <= 17'(item.self_y) - 17'(item.viewer_y);
			ey_s1   <= 18'(item.self_y) + SIGHT_Y_OFS - 18'(item.viewer_y);
			ux0_s1  <= 17'(item.viewer_x) - 17'(item.rect_x);
			ux1_s1  <= 18'(item.viewer_x) - 18'(item.rect_x) - $signed({3'b000, item.rect_w});
			uy0_s1  <= 17'(item.viewer_y) - 17'(item.rect_y);
			uy1_s1  <= 18'(item.viewer_y) - 18'(item.rect_y) - $signed({3'b000, item.rect_h});
			rw_s1   <= $signed({1'b0, item.rect_w});
			rh_s1   <= $signed({1'b0, item.rect_h});

			test_s2   <= test_s1;
			last_s2   <= last_s1;
			pv_den_s2 <= rh_s1 * ex_s1;
			pv_na0_s2 <= rh_s1 * ux0_s1;
			pv_na1_s2 <= rh_s1 * ux1_s1;
			ph_den_s2 <= rw_s1 * ey_s1;
			ph_na0_s2 <= rw_s1 * uy0_s1;
			ph_na1_s2 <= rw_s1 * uy1_s1;
			pe_y0_s2  <= ex_s1 * uy0_s1;
			pe_y1_s2  <= ex_s1 * uy1_s1;
			pe_x0_s2  <= ey_s1 * ux0_s1;
			pe_x1_s2  <= ey_s1 * ux1_s1;
			dx2_s2    <= ex_s1 * ex_s1;
			dy2_s2    <= dyr_s1 * dyr_s1;
			rsq_s2    <= view_radius * view_radius;

			test_s3   <= test_s2;
			last_s3   <= last_s2;
			inside_s3 <= inside_d;
			// left edge
			den_s3[0] <= NUM_W'(pv_den_s2);
			na_s3[0]  <= -NUM_W'(pv_na0_s2);
			nb_s3[0]  <= NUM_W'(pe_y0_s2) - NUM_W'(pe_x0_s2);
			// right edge
			den_s3[1] <= NUM_W'(pv_den_s2);
			na_s3[1]  <= -NUM_W'(pv_na1_s2);
			nb_s3[1]  <= NUM_W'(pe_y0_s2) - NUM_W'(pe_x1_s2);
			// bottom edge
			den_s3[2] <= -NUM_W'(ph_den_s2);
			na_s3[2]  <= NUM_W'(ph_na0_s2);
			nb_s3[2]  <= NUM_W'(pe_y0_s2) - NUM_W'(pe_x0_s2);
			// top edge
			den_s3[3] <= -NUM_W'(ph_den_s2);
			na_s3[3]  <= NUM_W'(ph_na1_s2);
			nb_s3[3]  <= NUM_W'(pe_y1_s2) - NUM_W'(pe_x0_s2);
		end
		if (adv && v_s3 && last_s3) begin
			visible_q <= !(blocked_q || hit_d);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			blocked_q <= 1'b0;
			out_v_q   <= 1'b0;
		end else begin
			if (adv) begin
				v_s1 <= item_valid;
				v_s2 <= v_s1;
				v_s3 <= v_s2;
			end
			if (adv && v_s3) begin
				if (last_s3) begin
					blocked_q <= 1'b0;
				end else if (hit_d) begin
					blocked_q <= 1'b1;
				end
			end
			if (adv && v_s3 && last_s3) begin
				out_v_q <= 1'b1;
			end else if (pop) begin
				out_v_q <= 1'b0;
			end
		end
	end

endmodule

// ===== hw/rtl/line_of_sight_occlusion_test.sv =====
// line_of_sight_occlusion_test: top level, config registers, front, queue and back
// a verdict reaches the result side through the stage 1, 2 and 3 registers and then the result register
// throughput: one item per cycle, set by the four-entry item queue and the 3-stage back
// the back stalls only while an unread verdict holds the result register
// reset: arst_n clears positions, blocked flag, queues, radius to 0 and skip to none
module line_of_sight_occlusion_test import los_pkg::*; #(
	parameter int MAX_RECTS = 256
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	output logic                      full,
	input  logic signed [COORD_W-1:0] viewer_x,
	input  logic signed [COORD_W-1:0] viewer_y,
	input  logic signed [COORD_W-1:0] self_x,
	input  logic signed [COORD_W-1:0] self_y,
	input  logic signed [COORD_W-1:0] rect_x,
	input  logic signed [COORD_W-1:0] rect_y,
	input  logic [SIZE_W-1:0]         rect_w,
	input  logic [SIZE_W-1:0]         rect_h,
	input  logic                      has_rect,
	input  logic                      last,
	output logic                      empty,
	input  logic                      pop,
	output logic                      visible,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CFG_IDX_W-1:0]      cfg_index,
	input  logic [CFG_DATA_W-1:0]     cfg_data
);

	logic [RAD_W-1:0]  view_radius_q;
	logic [SKIP_W-1:0] skip_index_q;

	logic              fifo_full;
	logic              fifo_empty;
	logic              wr_en;
	los_item_t         wr_item;
	logic              rd_en;
	los_item_t         rd_item;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			view_radius_q <= '0;
			skip_index_q  <= '1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_VIEW_RADIUS: view_radius_q <= cfg_data[RAD_W-1:0];
				REG_SKIP_INDEX:  skip_index_q  <= cfg_data[SKIP_W-1:0];
				default: ;
			endcase
		end
	end

	los_front #(
		.MAX_RECTS(MAX_RECTS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.viewer_x   (viewer_x),
		.viewer_y   (viewer_y),
		.self_x     (self_x),
		.self_y     (self_y),
		.rect_x     (rect_x),
		.rect_y     (rect_y),
		.rect_w     (rect_w),
		.rect_h     (rect_h),
		.has_rect   (has_rect),
		.last       (last),
		.skip_index (skip_index_q),
		.fifo_full  (fifo_full),
		.wr_en      (wr_en),
		.wr_item    (wr_item)
	);

	los_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_item (wr_item),
		.full    (fifo_full),
		.rd_en   (rd_en),
		.rd_item (rd_item),
		.empty   (fifo_empty)
	);

	los_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.view_radius (view_radius_q),
		.item_valid  (!fifo_empty),
		.item        (rd_item),
		.item_pop    (rd_en),
		.pop         (pop),
		.empty       (empty),
		.visible     (visible)
	);

endmodule
